### rtl/core/msc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the memory snapshot compare filter.
// No dependencies; every other file of the block but msc_ram refers to this package.
package msc_pkg;

    localparam int MEM_DEPTH   = 131072;
    localparam int BYTE_W      = 8;
    localparam int OFF_W       = 17;
    localparam int WIN_W       = 32;
    localparam int LEN_W       = 18;
    localparam int CMD_W       = 2;
    localparam int MODE_W      = 3;
    localparam int DW_W        = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int NBANK       = WIN_W / BYTE_W;
    localparam int BANK_SEL_W  = $clog2(NBANK);
    localparam int BANK_DEPTH  = MEM_DEPTH / NBANK;
    localparam int BANK_AW     = $clog2(BANK_DEPTH);
    localparam int CAND_ROW_W  = 32;
    localparam int CAND_SH     = $clog2(CAND_ROW_W);
    localparam int CAND_ROWS   = MEM_DEPTH / CAND_ROW_W;
    localparam int CAND_AW     = $clog2(CAND_ROWS);
    localparam int QDEPTH      = 4;
    localparam int Q_AW        = $clog2(QDEPTH);
    localparam int Q_CW        = $clog2(QDEPTH + 1);
    localparam int OF_DEPTH    = 4;
    localparam int OF_AW       = $clog2(OF_DEPTH);
    localparam int OF_CW       = $clog2(OF_DEPTH + 1);
    localparam int DEPTH_LEN_W = $clog2(MEM_DEPTH + 1);
    localparam int CMP_W       = (DEPTH_LEN_W > LEN_W) ? DEPTH_LEN_W : LEN_W;
    localparam int VAL_W       = WIN_W + 1;

    localparam logic [DW_W-1:0] DW_FULL = DW_W'(NBANK - 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_COMPARE = 2'd1,
        CMD_QUERY   = 2'd2
    } t_cmd;

    typedef enum logic [MODE_W-1:0] {
        MODE_LT = 3'd0,
        MODE_GT = 3'd1,
        MODE_LE = 3'd2,
        MODE_GE = 3'd3,
        MODE_EQ = 3'd4,
        MODE_NE = 3'd5
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COMPARE_MODE     = 3'd0,
        REG_DATA_WIDTH       = 3'd1,
        REG_SIGNED_COMPARE   = 3'd2,
        REG_REFRESH_SNAPSHOT = 3'd3,
        REG_AGAINST_CONSTANT = 3'd4,
        REG_COMPARE_VALUE    = 3'd5,
        REG_REGION_LENGTH    = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_CMP   = 2'd2,
        KIND_QUERY = 2'd3
    } t_kind;

    typedef struct packed {
        logic [MODE_W-1:0] compare_mode;
        logic [DW_W-1:0]   data_width;
        logic              signed_compare;
        logic              refresh_snapshot;
        logic              against_constant;
        logic [WIN_W-1:0]  compare_value;
        logic [LEN_W-1:0]  region_length;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        compare_mode:     MODE_EQ,
        data_width:       '0,
        signed_compare:   1'b0,
        refresh_snapshot: 1'b0,
        against_constant: 1'b0,
        compare_value:    '0,
        region_length:    LEN_W'(MEM_DEPTH)
    };

    typedef struct packed {
        t_kind             kind;
        logic [OFF_W-1:0]  offset;
        logic [WIN_W-1:0]  cur_window;
    } t_item;

    typedef struct packed {
        logic [OFF_W-1:0]  out_offset;
        logic              still_candidate;
        logic [BYTE_W-1:0] current_byte;
    } t_result;

    typedef struct packed {
        logic [Q_CW-1:0] q_count;
    } t_front_stat;

    typedef struct packed {
        logic             clr_busy;
        logic [OF_CW-1:0] out_count;
    } t_back_stat;

    // Extend the low (dw + 1) bytes of v to a signed value one bit wider than the word.
    function automatic logic signed [VAL_W-1:0] ext(input logic [WIN_W-1:0] v,
                                                     input logic [DW_W-1:0] dw,
                                                     input logic sg);
        logic             s;
        logic [VAL_W-1:0] r;
        unique case (dw)
            2'd0: begin
                s = sg & v[7];
                r = {{25{s}}, v[7:0]};
            end
            2'd1: begin
                s = sg & v[15];
                r = {{17{s}}, v[15:0]};
            end
            2'd2: begin
                s = sg & v[23];
                r = {{9{s}}, v[23:0]};
            end
            2'd3: begin
                s = sg & v[31];
                r = {s, v};
            end
        endcase
        return $signed(r);
    endfunction

endpackage

### rtl/core/msc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: input words, result words and register writes.
// Depends on msc_pkg for field widths.
interface msc_in_if;
    logic                            valid;
    logic                            ready;
    logic [msc_pkg::CMD_W-1:0]       cmd;
    logic [msc_pkg::OFF_W-1:0]       offset;
    logic [msc_pkg::WIN_W-1:0]       cur_window;

    modport source (output valid, cmd, offset, cur_window, input ready);
    modport sink   (input valid, cmd, offset, cur_window, output ready);
endinterface

interface msc_out_if;
    logic                            valid;
    logic                            ready;
    logic [msc_pkg::OFF_W-1:0]       out_offset;
    logic                            still_candidate;
    logic [msc_pkg::BYTE_W-1:0]      current_byte;

    modport source (output valid, out_offset, still_candidate, current_byte, input ready);
    modport sink   (input valid, out_offset, still_candidate, current_byte, output ready);
endinterface

interface msc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [msc_pkg::CFG_IDX_W-1:0]   index;
    logic [msc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/memory_snapshot_compare_filter.sv
`timescale 1ns / 1ps
// Top level of the memory snapshot compare filter: register file, front, back.
// Depends on msc_pkg, msc_if, msc_front, msc_back and msc_ram.
//
// Usage:
//   i_item   - command words (load snapshot byte, compare step, query) with an
//              offset and the current four bytes at that offset.
//   o_result - one word per command: offset, candidate bit after the step and
//              the low current byte.
//   i_cfg    - register writes (index, data); always ready. Write only while
//              no command is in flight.
// Throughput is one word per cycle while o_result is ready: each command reads
// the four snapshot byte banks and a 32-bit candidate row, written back for
// loads and compares, with same-address writes of the previous cycle forwarded.
// Each word goes through the command queue, compare stage and result queue.
// After reset the candidate rows are cleared one row a cycle;
// i_item.ready stays low during that pass, register writes are taken.
// When o_result stalls, a 4-word result queue and a 4-word command queue fill
// and i_item.ready drops; no word is lost.
module memory_snapshot_compare_filter (
    input  logic      i_clk,
    input  logic      i_rst_n,
    msc_in_if.sink    i_item,
    msc_out_if.source o_result,
    msc_cfg_if.sink   i_cfg
);

    msc_pkg::t_cfg         r_cfg;
    logic                  w_q_valid;
    msc_pkg::t_item        w_q_head;
    logic                  w_pop;
    msc_pkg::t_front_stat  w_fstat;
    msc_pkg::t_back_stat   w_bstat;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= msc_pkg::CFG_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (msc_pkg::t_reg_idx'(i_cfg.index))
                msc_pkg::REG_COMPARE_MODE:
                    r_cfg.compare_mode <= i_cfg.data[msc_pkg::MODE_W-1:0];
                msc_pkg::REG_DATA_WIDTH:
                    r_cfg.data_width <= i_cfg.data[msc_pkg::DW_W-1:0];
                msc_pkg::REG_SIGNED_COMPARE:
                    r_cfg.signed_compare <= i_cfg.data[0];
                msc_pkg::REG_REFRESH_SNAPSHOT:
                    r_cfg.refresh_snapshot <= i_cfg.data[0];
                msc_pkg::REG_AGAINST_CONSTANT:
                    r_cfg.against_constant <= i_cfg.data[0];
                msc_pkg::REG_COMPARE_VALUE:
                    r_cfg.compare_value <= i_cfg.data[msc_pkg::WIN_W-1:0];
                msc_pkg::REG_REGION_LENGTH:
                    r_cfg.region_length <= i_cfg.data[msc_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    msc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg      (r_cfg),
        .i_clr_busy (w_bstat.clr_busy),
        .i_pop      (w_pop),
        .o_q_valid  (w_q_valid),
        .o_q_head   (w_q_head),
        .o_stat     (w_fstat)
    );

    msc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .i_q_head  (w_q_head),
        .o_pop     (w_pop),
        .o_result  (o_result),
        .o_stat    (w_bstat)
    );

`ifndef SYNTH
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bstat.clr_busy |-> !(i_item.valid && i_item.ready))
        else $error("command accepted during candidate clear");

    a_no_result_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(w_bstat.clr_busy) |-> !o_result.valid)
        else $error("result present right after candidate clear");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fstat.q_count <= msc_pkg::Q_CW'(msc_pkg::QDEPTH))
        else $error("command queue overflow");

    a_result_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bstat.out_count <= msc_pkg::OF_CW'(msc_pkg::OF_DEPTH))
        else $error("result queue overflow");
`endif

endmodule

### rtl/core/msc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Read during write to the same address returns the old contents.
module msc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/msc_front.sv
`timescale 1ns / 1ps
// Front end: accepts input words, classifies them against the region bound
// and queues them for the back end. Depends on msc_pkg and msc_if.
module msc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    msc_in_if.sink                i_item,
    input  msc_pkg::t_cfg         i_cfg,
    input  logic                  i_clr_busy,
    input  logic                  i_pop,
    output logic                  o_q_valid,
    output msc_pkg::t_item        o_q_head,
    output msc_pkg::t_front_stat  o_stat
);

    msc_pkg::t_item                r_q [msc_pkg::QDEPTH];
    logic [msc_pkg::Q_AW-1:0]      r_wp, n_wp;
    logic [msc_pkg::Q_AW-1:0]      r_rp, n_rp;
    logic [msc_pkg::Q_CW-1:0]      r_cnt, n_cnt;

    logic [msc_pkg::CMP_W-1:0]     w_len;
    logic [msc_pkg::CMP_W-1:0]     w_off;
    logic [msc_pkg::CMP_W-1:0]     w_end;
    logic                          w_in_region;
    logic                          w_win_ok;
    logic                          w_push;
    msc_pkg::t_item                w_item;

    always_comb begin
        w_len = (msc_pkg::CMP_W'(i_cfg.region_length) > msc_pkg::CMP_W'(msc_pkg::MEM_DEPTH))
              ? msc_pkg::CMP_W'(msc_pkg::MEM_DEPTH)
              : msc_pkg::CMP_W'(i_cfg.region_length);
        w_off       = msc_pkg::CMP_W'(i_item.offset);
        w_end       = w_off + msc_pkg::CMP_W'(i_cfg.data_width);
        w_in_region = w_off < w_len;
        w_win_ok    = w_end < w_len;

        w_item.offset     = i_item.offset;
        w_item.cur_window = i_item.cur_window;
        if (!w_in_region) begin
            w_item.kind = msc_pkg::KIND_NONE;
        end else begin
            unique case (msc_pkg::t_cmd'(i_item.cmd))
                msc_pkg::CMD_LOAD:    w_item.kind = msc_pkg::KIND_LOAD;
                msc_pkg::CMD_COMPARE: w_item.kind = w_win_ok ? msc_pkg::KIND_CMP
                                                             : msc_pkg::KIND_QUERY;
                msc_pkg::CMD_QUERY:   w_item.kind = msc_pkg::KIND_QUERY;
                default:              w_item.kind = msc_pkg::KIND_QUERY;
            endcase
        end
    end

    assign i_item.ready = (r_cnt != msc_pkg::Q_CW'(msc_pkg::QDEPTH)) && !i_clr_busy;
    assign w_push       = i_item.valid && i_item.ready;

    always_comb begin
        n_wp  = w_push ? r_wp + msc_pkg::Q_AW'(1) : r_wp;
        n_rp  = i_pop ? r_rp + msc_pkg::Q_AW'(1) : r_rp;
        n_cnt = r_cnt + msc_pkg::Q_CW'(w_push) - msc_pkg::Q_CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    assign o_q_valid      = r_cnt != '0;
    assign o_q_head       = r_q[r_rp];
    assign o_stat.q_count = r_cnt;

endmodule

### rtl/core/msc_back.sv
`timescale 1ns / 1ps
// Back end: snapshot banks and candidate rows, compare, write back, result queue.
// Depends on msc_pkg, msc_if and msc_ram.
module msc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  msc_pkg::t_cfg        i_cfg,
    input  logic                 i_q_valid,
    input  msc_pkg::t_item       i_q_head,
    output logic                 o_pop,
    msc_out_if.source            o_result,
    output msc_pkg::t_back_stat  o_stat
);

    // clearing pass
    logic                                r_clr_busy;
    logic [msc_pkg::CAND_AW-1:0]         r_clr_row;

    // compare stage
    logic                                r_s2_v;
    msc_pkg::t_item                      r_s2;
    logic [msc_pkg::BANK_AW-1:0]         r_s2_rows [msc_pkg::NBANK];

    // write forwarding
    logic                                r_fs_v;
    logic [msc_pkg::BANK_SEL_W-1:0]      r_fs_bank;
    logic [msc_pkg::BANK_AW-1:0]         r_fs_row;
    logic [msc_pkg::BYTE_W-1:0]          r_fs_data;
    logic                                r_fc_v;
    logic [msc_pkg::CAND_AW-1:0]         r_fc_row;
    logic [msc_pkg::CAND_ROW_W-1:0]      r_fc_data;

    // result queue
    msc_pkg::t_result                    r_of [msc_pkg::OF_DEPTH];
    logic [msc_pkg::OF_AW-1:0]           r_owp, r_orp;
    logic [msc_pkg::OF_CW-1:0]           r_ocnt, n_ocnt;

    logic [msc_pkg::BANK_AW-1:0]         w_rows [msc_pkg::NBANK];
    logic [msc_pkg::BANK_AW-1:0]         w_base;
    logic [msc_pkg::BYTE_W-1:0]          w_snap_rd [msc_pkg::NBANK];
    logic [msc_pkg::BYTE_W-1:0]          w_bank_d [msc_pkg::NBANK];
    logic [msc_pkg::BANK_SEL_W-1:0]      w_sel [msc_pkg::NBANK];
    logic [msc_pkg::CAND_ROW_W-1:0]      w_cand_rd;
    logic [msc_pkg::CAND_ROW_W-1:0]      w_crow_d;
    logic [msc_pkg::CAND_ROW_W-1:0]      w_cdata;
    logic [msc_pkg::CAND_AW-1:0]         w_crow;
    logic [msc_pkg::CAND_SH-1:0]         w_cbit;
    logic [msc_pkg::WIN_W-1:0]           w_win;
    logic signed [msc_pkg::VAL_W-1:0]    w_a, w_b;
    logic                                w_rel;
    logic                                w_old;
    logic                                w_new;
    logic                                w_cw;
    logic                                w_sw;
    logic [msc_pkg::BANK_SEL_W-1:0]      w_sbank;
    logic                                w_cram_we;
    logic [msc_pkg::CAND_AW-1:0]         w_cram_wa;
    logic [msc_pkg::CAND_ROW_W-1:0]      w_cram_wd;
    logic                                w_drain;
    msc_pkg::t_result                    w_res;

    // issue: pop only when the result queue has room for everything in flight
    assign o_pop = i_q_valid && !r_clr_busy
                && ((r_ocnt + msc_pkg::OF_CW'(r_s2_v)) < msc_pkg::OF_CW'(msc_pkg::OF_DEPTH));

    always_comb begin
        w_base = msc_pkg::BANK_AW'(i_q_head.offset >> msc_pkg::BANK_SEL_W);
        for (int b = 0; b < msc_pkg::NBANK; b++) begin
            w_rows[b] = w_base
                      + ((msc_pkg::BANK_SEL_W'(b) < i_q_head.offset[msc_pkg::BANK_SEL_W-1:0])
                         ? msc_pkg::BANK_AW'(1) : '0);
        end
    end

    for (genvar g = 0; g < msc_pkg::NBANK; g++) begin : g_bank
        msc_ram #(
            .WIDTH (msc_pkg::BYTE_W),
            .DEPTH (msc_pkg::BANK_DEPTH)
        ) u_snap (
            .i_clk   (i_clk),
            .i_we    (w_sw && (w_sbank == msc_pkg::BANK_SEL_W'(g))),
            .i_waddr (r_s2_rows[w_sbank]),
            .i_wdata (r_s2.cur_window[msc_pkg::BYTE_W-1:0]),
            .i_raddr (w_rows[g]),
            .o_rdata (w_snap_rd[g])
        );
    end

    msc_ram #(
        .WIDTH (msc_pkg::CAND_ROW_W),
        .DEPTH (msc_pkg::CAND_ROWS)
    ) u_cand (
        .i_clk   (i_clk),
        .i_we    (w_cram_we),
        .i_waddr (w_cram_wa),
        .i_wdata (w_cram_wd),
        .i_raddr (msc_pkg::CAND_AW'(i_q_head.offset >> msc_pkg::CAND_SH)),
        .o_rdata (w_cand_rd)
    );

    // compare and write back
    always_comb begin
        for (int b = 0; b < msc_pkg::NBANK; b++) begin
            w_bank_d[b] = (r_fs_v && (r_fs_bank == msc_pkg::BANK_SEL_W'(b))
                           && (r_fs_row == r_s2_rows[b])) ? r_fs_data : w_snap_rd[b];
        end
        for (int k = 0; k < msc_pkg::NBANK; k++) begin
            w_sel[k] = r_s2.offset[msc_pkg::BANK_SEL_W-1:0] + msc_pkg::BANK_SEL_W'(k);
            w_win[k*msc_pkg::BYTE_W +: msc_pkg::BYTE_W] = w_bank_d[w_sel[k]];
        end

        w_crow   = msc_pkg::CAND_AW'(r_s2.offset >> msc_pkg::CAND_SH);
        w_cbit   = r_s2.offset[msc_pkg::CAND_SH-1:0];
        w_crow_d = (r_fc_v && (r_fc_row == w_crow)) ? r_fc_data : w_cand_rd;
        w_old    = w_crow_d[w_cbit];

        w_a = msc_pkg::ext(r_s2.cur_window, i_cfg.data_width, i_cfg.signed_compare);
        w_b = i_cfg.against_constant
            ? msc_pkg::ext(i_cfg.compare_value, msc_pkg::DW_FULL, i_cfg.signed_compare)
            : msc_pkg::ext(w_win, i_cfg.data_width, i_cfg.signed_compare);

        unique case (msc_pkg::t_mode'(i_cfg.compare_mode))
            msc_pkg::MODE_LT: w_rel = w_a < w_b;
            msc_pkg::MODE_GT: w_rel = w_a > w_b;
            msc_pkg::MODE_LE: w_rel = w_a <= w_b;
            msc_pkg::MODE_GE: w_rel = w_a >= w_b;
            msc_pkg::MODE_EQ: w_rel = w_a == w_b;
            msc_pkg::MODE_NE: w_rel = w_a != w_b;
            default:          w_rel = w_a != w_b;
        endcase

        w_cw = 1'b0;
        w_sw = 1'b0;
        unique case (r_s2.kind)
            msc_pkg::KIND_NONE:  w_new = 1'b0;
            msc_pkg::KIND_LOAD: begin
                w_new = 1'b1;
                w_cw  = r_s2_v;
                w_sw  = r_s2_v;
            end
            msc_pkg::KIND_CMP: begin
                w_new = w_old && w_rel;
                w_cw  = r_s2_v;
                w_sw  = r_s2_v && w_new && i_cfg.refresh_snapshot;
            end
            msc_pkg::KIND_QUERY: w_new = w_old;
        endcase

        w_sbank         = r_s2.offset[msc_pkg::BANK_SEL_W-1:0];
        w_cdata         = w_crow_d;
        w_cdata[w_cbit] = w_new;

        w_cram_we = r_clr_busy || w_cw;
        w_cram_wa = r_clr_busy ? r_clr_row : w_crow;
        w_cram_wd = r_clr_busy ? '0 : w_cdata;

        w_res.out_offset      = r_s2.offset;
        w_res.still_candidate = w_new;
        w_res.current_byte    = r_s2.cur_window[msc_pkg::BYTE_W-1:0];
    end

    assign w_drain = o_result.valid && o_result.ready;
    assign n_ocnt  = r_ocnt + msc_pkg::OF_CW'(r_s2_v) - msc_pkg::OF_CW'(w_drain);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_row  <= '0;
            r_s2_v     <= 1'b0;
            r_fs_v     <= 1'b0;
            r_fc_v     <= 1'b0;
            r_owp      <= '0;
            r_orp      <= '0;
            r_ocnt     <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_row <= r_clr_row + msc_pkg::CAND_AW'(1);
                if (r_clr_row == msc_pkg::CAND_AW'(msc_pkg::CAND_ROWS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_s2_v <= o_pop;
            r_fs_v <= w_sw;
            r_fc_v <= w_cw;
            if (r_s2_v) begin
                r_owp <= r_owp + msc_pkg::OF_AW'(1);
            end
            if (w_drain) begin
                r_orp <= r_orp + msc_pkg::OF_AW'(1);
            end
            r_ocnt <= n_ocnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s2 <= i_q_head;
            for (int b = 0; b < msc_pkg::NBANK; b++) begin
                r_s2_rows[b] <= w_rows[b];
            end
        end
        r_fs_bank <= w_sbank;
        r_fs_row  <= r_s2_rows[w_sbank];
        r_fs_data <= r_s2.cur_window[msc_pkg::BYTE_W-1:0];
        r_fc_row  <= w_crow;
        r_fc_data <= w_cdata;
        if (r_s2_v) begin
            r_of[r_owp] <= w_res;
        end
    end

    assign o_result.valid           = r_ocnt != '0;
    assign o_result.out_offset      = r_of[r_orp].out_offset;
    assign o_result.still_candidate = r_of[r_orp].still_candidate;
    assign o_result.current_byte    = r_of[r_orp].current_byte;

    assign o_stat.clr_busy  = r_clr_busy;
    assign o_stat.out_count = r_ocnt;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for memory_snapshot_compare_filter: directed and random command
// words, checked result by result against a scoreboard that predicts the filter state.
// Depends on msc_pkg, msc_if and the RTL of the filter.
module tb;
    import msc_pkg::*;

    localparam logic [CMD_W-1:0]     CMD_SPARE   = 2'd3;
    localparam logic [MODE_W-1:0]    MODE_SPARE6 = 3'd6;
    localparam logic [MODE_W-1:0]    MODE_SPARE7 = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 3'd7;
    localparam logic [OFF_W-1:0]     MAX_OFF     = '1;
    localparam int EXT_W       = WIN_W + 2;
    localparam int LATENCY     = 3;
    localparam int LONG_HOLD   = 80;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 12;
    localparam int PHASE_WORDS = 55;

    class filter_scoreboard;
        t_cfg       regs;
        logic [7:0] snap[int];
        bit         cand[int];
        t_result    expected_q[$];
        int         errors;

        function new();
            regs   = CFG_RESET;
            errors = 0;
        endfunction

        function int unsigned live_length();
            return (regs.region_length > MEM_DEPTH) ? MEM_DEPTH : regs.region_length;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                REG_COMPARE_MODE:     regs.compare_mode     = d[MODE_W-1:0];
                REG_DATA_WIDTH:       regs.data_width       = d[DW_W-1:0];
                REG_SIGNED_COMPARE:   regs.signed_compare   = d[0];
                REG_REFRESH_SNAPSHOT: regs.refresh_snapshot = d[0];
                REG_AGAINST_CONSTANT: regs.against_constant = d[0];
                REG_COMPARE_VALUE:    regs.compare_value    = d[WIN_W-1:0];
                REG_REGION_LENGTH:    regs.region_length    = d[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function logic signed [EXT_W-1:0] widen(logic [WIN_W-1:0] v, int nbytes, bit sg);
            logic [EXT_W-1:0] r;
            int               nbits;
            nbits = 8 * nbytes;
            r = {2'b00, v};
            if (nbits < WIN_W) r = r & ((EXT_W'(1) << nbits) - EXT_W'(1));
            if (sg && v[nbits-1]) r = r - (EXT_W'(1) << nbits);
            return $signed(r);
        endfunction

        function bit holds(logic [MODE_W-1:0] mode, logic signed [EXT_W-1:0] a,
                           logic signed [EXT_W-1:0] b);
            case (mode)
                MODE_LT: return a < b;
                MODE_GT: return a > b;
                MODE_LE: return a <= b;
                MODE_GE: return a >= b;
                MODE_EQ: return a == b;
                default: return a != b;
            endcase
        endfunction

        // True when a compare at o touches only snapshot bytes that were loaded.
        function bit window_safe(logic [OFF_W-1:0] o);
            int unsigned len;
            int          k;
            len = live_length();
            if (regs.against_constant || o >= len || o + regs.data_width >= len) return 1'b1;
            for (k = 0; k <= regs.data_width; k++)
                if (!snap.exists(int'(o) + k)) return 1'b0;
            return 1'b1;
        endfunction

        function void note_word(logic [CMD_W-1:0] c, logic [OFF_W-1:0] o, logic [WIN_W-1:0] w);
            int unsigned             len;
            int                      nbytes, k, at;
            logic [WIN_W-1:0]        old_win;
            logic signed [EXT_W-1:0] a, b;
            bit                      still;
            t_result                 r;
            len   = live_length();
            at    = o;
            still = 1'b0;
            if (at < len) begin
                if (c == CMD_LOAD) begin
                    snap[at] = w[7:0];
                    cand[at] = 1'b1;
                end else if (c == CMD_COMPARE && at + regs.data_width < len) begin
                    nbytes = regs.data_width + 1;
                    a = widen(w, nbytes, regs.signed_compare);
                    if (regs.against_constant) begin
                        b = widen(regs.compare_value, 4, regs.signed_compare);
                    end else begin
                        old_win = '0;
                        for (k = 0; k < nbytes; k++)
                            old_win[8*k +: 8] = snap.exists(at + k) ? snap[at + k] : 8'h00;
                        b = widen(old_win, nbytes, regs.signed_compare);
                    end
                    if (cand.exists(at) && cand[at] && holds(regs.compare_mode, a, b)) begin
                        if (regs.refresh_snapshot) snap[at] = w[7:0];
                    end else begin
                        cand[at] = 1'b0;
                    end
                end
                still = cand.exists(at) ? cand[at] : 1'b0;
            end
            r.out_offset      = o;
            r.still_candidate = still;
            r.current_byte    = w[7:0];
            expected_q.push_back(r);
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] %s", $time, what);
        endtask

        task check_result(logic [OFF_W-1:0] o, logic c, logic [BYTE_W-1:0] b);
            t_result e;
            if (expected_q.size() == 0) begin
                report($sformatf("result word with none expected: offset %0d", o));
                return;
            end
            e = expected_q.pop_front();
            if (o !== e.out_offset || c !== e.still_candidate || b !== e.current_byte)
                report($sformatf("result mismatch got/exp: offset %0d/%0d cand %b/%b byte %h/%h",
                                 o, e.out_offset, c, e.still_candidate, b, e.current_byte));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    msc_in_if  item_bus ();
    msc_out_if result_bus ();
    msc_cfg_if cfg_bus ();

    filter_scoreboard sb;
    int cycles     = 0;
    bit send_calm  = 1'b0;
    bit recv_calm  = 1'b0;
    int stall_left = 0;
    int hold_asks  = 0;
    int holds_done = 0;
    int bases[4];

    memory_snapshot_compare_filter dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .o_result (result_bus),
        .i_cfg    (cfg_bus)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles[6:0] == 7'd0) begin
            send_calm <= ($urandom_range(0, 3) == 0);
            recv_calm <= ($urandom_range(0, 3) == 0);
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int idle_length(bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 96) return $urandom_range(3, 8);
        return $urandom_range(12, 30);
    endfunction

    always @(posedge i_clk) begin : receive
        int n;
        if (i_rst_n === 1'b1 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
            sb.check_result(result_bus.out_offset, result_bus.still_candidate,
                            result_bus.current_byte);
        if (stall_left > 0) begin
            result_bus.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (holds_done != hold_asks) begin
            result_bus.ready <= 1'b0;
            stall_left <= LONG_HOLD;
            holds_done <= holds_done + 1;
        end else begin
            n = ($urandom_range(0, 3) == 0) ? idle_length(recv_calm) : 0;
            result_bus.ready <= (n == 0);
            if (n > 0) stall_left <= n - 1;
        end
    end

    task automatic push_word(input logic [CMD_W-1:0] c, input logic [OFF_W-1:0] o,
                             input logic [WIN_W-1:0] w);
        int gap;
        gap = idle_length(send_calm);
        if (gap > 0) begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_bus.valid      <= 1'b1;
        item_bus.cmd        <= c;
        item_bus.offset     <= o;
        item_bus.cur_window <= w;
        @(posedge i_clk);
        while (item_bus.ready !== 1'b1) @(posedge i_clk);
        sb.note_word(c, o, w);
    endtask

    // Demote a compare that would read never-loaded snapshot bytes to a load.
    task automatic issue(input logic [CMD_W-1:0] c, input logic [OFF_W-1:0] o,
                         input logic [WIN_W-1:0] w);
        if (c == CMD_COMPARE && !sb.window_safe(o)) c = CMD_LOAD;
        push_word(c, o, w);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= d;
        @(posedge i_clk);
        while (cfg_bus.ready !== 1'b1) @(posedge i_clk);
        sb.write_reg(idx, d);
    endtask

    task automatic settle();
        item_bus.valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic configure(input logic [MODE_W-1:0] mode, input logic [DW_W-1:0] dw,
                             input bit sg, input bit refresh, input bit against,
                             input logic [WIN_W-1:0] cv, input logic [LEN_W-1:0] len);
        settle();
        set_reg(REG_COMPARE_MODE, mode);
        set_reg(REG_DATA_WIDTH, dw);
        set_reg(REG_SIGNED_COMPARE, sg);
        set_reg(REG_REFRESH_SNAPSHOT, refresh);
        set_reg(REG_AGAINST_CONSTANT, against);
        set_reg(REG_COMPARE_VALUE, cv);
        set_reg(REG_REGION_LENGTH, len);
        set_reg(REG_SPARE, $urandom());
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic logic [WIN_W-1:0] probe_window(logic [OFF_W-1:0] o);
        logic [WIN_W-1:0] ref_w, mask;
        int               k, nbits;
        nbits = 8 * (sb.regs.data_width + 1);
        mask  = (nbits == WIN_W) ? '1 : ((WIN_W'(1) << nbits) - WIN_W'(1));
        if (sb.regs.against_constant) begin
            ref_w = sb.regs.compare_value;
        end else begin
            for (k = 0; k < 4; k++)
                ref_w[8*k +: 8] = sb.snap.exists(int'(o) + k) ? sb.snap[int'(o) + k]
                                                              : 8'($urandom());
        end
        case ($urandom_range(0, 5))
            0, 1:    return ref_w ^ ($urandom() & ~mask);
            2:       return ref_w + $urandom_range(1, 3);
            3:       return ref_w - $urandom_range(1, 3);
            4:       return ref_w ^ (WIN_W'(1) << (nbits - 1));
            default: return $urandom();
        endcase
    endfunction

    // Load most of a 4-byte window, compare at its start a few times, maybe query.
    task automatic well_formed(input int base, inout int budget);
        logic [OFF_W-1:0] o;
        int               k, reps;
        o = base[OFF_W-1:0];
        for (k = 0; k < 4 && budget > 0; k++) begin
            if ($urandom_range(0, 9) != 0) begin
                push_word(CMD_LOAD, o + k, $urandom());
                budget--;
            end
        end
        reps = $urandom_range(1, 5);
        for (k = 0; k < reps && budget > 0; k++) begin
            issue(CMD_COMPARE, o, probe_window(o));
            budget--;
        end
        if ($urandom_range(0, 2) == 0 && budget > 0) begin
            issue(CMD_QUERY, o, $urandom());
            budget--;
        end
    endtask

    task automatic noise_word();
        logic [OFF_W-1:0] o;
        int               r;
        r = $urandom_range(0, 9);
        if (r < 5)      o = bases[$urandom_range(0, 3)] + $urandom_range(0, 7);
        else if (r < 8) o = $urandom_range(0, MEM_DEPTH - 1);
        else            o = $urandom_range(0, sb.live_length() - 1);
        issue($urandom_range(0, 3), o, $urandom());
    endtask

    initial begin
        int                  p, budget, len_eff;
        logic [WIN_W-1:0]    cv;
        logic [LEN_W-1:0]    len;
        sb = new();
        i_rst_n             = 1'b0;
        item_bus.valid      = 1'b0;
        item_bus.cmd        = '0;
        item_bus.offset     = '0;
        item_bus.cur_window = '0;
        result_bus.ready    = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = '0;
        cfg_bus.data        = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_word(CMD_QUERY, 0, 32'h0000_0000);
        push_word(CMD_QUERY, MAX_OFF, 32'hFFFF_FFFF);
        push_word(CMD_LOAD, 0, 32'hFFFF_FF80);
        push_word(CMD_LOAD, 1, 32'h0000_007F);
        push_word(CMD_LOAD, 2, 32'h1234_5600);
        push_word(CMD_LOAD, 3, 32'h0000_00FF);
        push_word(CMD_LOAD, MAX_OFF, 32'hA5A5_A55A);
        push_word(CMD_COMPARE, 0, 32'h0000_0080);
        push_word(CMD_COMPARE, 1, 32'h0000_0080);
        push_word(CMD_COMPARE, 1, 32'h0000_007F);
        push_word(CMD_SPARE, 0, 32'h0000_0011);
        push_word(CMD_COMPARE, MAX_OFF, 32'h0000_005A);

        configure(MODE_LT, DW_FULL, 1'b1, 1'b1, 1'b0, 32'h0, LEN_W'(MEM_DEPTH));
        push_word(CMD_COMPARE, 0, 32'h8000_0000);
        push_word(CMD_COMPARE, MAX_OFF - 2, 32'h0000_0000);
        push_word(CMD_COMPARE, MAX_OFF, 32'hFFFF_FFFF);

        configure(MODE_SPARE6, 2'd0, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF, 18'd16);
        push_word(CMD_COMPARE, 0, 32'h0000_0000);
        push_word(CMD_COMPARE, 0, 32'hFFFF_FFFF);
        push_word(CMD_LOAD, 20, 32'h0000_0033);
        push_word(CMD_QUERY, MAX_OFF, 32'h0000_0000);

        configure(MODE_SPARE7, DW_FULL, 1'b0, 1'b0, 1'b0, 32'h0, 18'd0);
        push_word(CMD_LOAD, 0, 32'h0000_0044);
        push_word(CMD_COMPARE, 15, 32'h0000_0000);

        configure(MODE_GE, 2'd1, 1'b0, 1'b1, 1'b0, 32'h0, LEN_W'(MEM_DEPTH));
        push_word(CMD_COMPARE, 2, 32'h0000_FF00);
        push_word(CMD_COMPARE, 2, 32'h0000_0000);

        for (p = 0; p < PHASES; p++) begin
            case (p % 5)
                0:       cv = 32'h0000_0000;
                1:       cv = 32'hFFFF_FFFF;
                2:       cv = 32'h8000_0000;
                3:       cv = 32'h7FFF_FFFF;
                default: cv = ($urandom_range(0, 1) == 1) ? $urandom() : $urandom_range(0, 300);
            endcase
            if (p == 3)          len = 18'd1;
            else if (p == 7)     len = '1;
            else if (p == 9)     len = LEN_W'(MEM_DEPTH);
            else if (p % 2 == 0) len = $urandom_range(1024, MEM_DEPTH);
            else                 len = $urandom_range(8, 300);
            configure((p < 8) ? MODE_W'(p) : MODE_W'($urandom_range(0, 7)), DW_W'(p % 4),
                      $urandom_range(0, 1), $urandom_range(0, 1), (p % 3 == 2), cv, len);

            len_eff  = sb.live_length();
            bases[0] = 0;
            bases[1] = (len_eff > 6) ? len_eff - 1 - $urandom_range(0, 5) : 0;
            bases[2] = $urandom_range(0, len_eff - 1);
            bases[3] = $urandom_range(0, MEM_DEPTH - 1);
            // stall results while words keep coming so the input backs up
            if (p == 4) hold_asks++;

            budget = PHASE_WORDS;
            while (budget > 0) begin
                if ($urandom_range(0, 3) != 0) begin
                    if ($urandom_range(0, 9) < 7)
                        well_formed(bases[$urandom_range(0, 3)], budget);
                    else
                        well_formed($urandom_range(0, len_eff - 1), budget);
                end else begin
                    noise_word();
                    budget--;
                end
            end
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
